// ----- sv/dbpp_pkg.sv -----
// dbpp_pkg: shared types and constants of the depth band point projector
// register map, configuration record, stage records and arithmetic constants
// no dependencies
package dbpp_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_BAND_LOW    = 3'd0,
    REG_BAND_HIGH   = 3'd1,
    REG_RANGE_NEAR  = 3'd2,
    REG_RANGE_FAR   = 3'd3,
    REG_CENTER_X    = 3'd4,
    REG_CENTER_Y    = 3'd5,
    REG_INV_FOCAL_X = 3'd6,
    REG_INV_FOCAL_Y = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [8:0]  band_low;
    logic [8:0]  band_high;
    logic [9:0]  range_near_cm;
    logic [9:0]  range_far_cm;
    logic [17:0] center_x_q8;
    logic [17:0] center_y_q8;
    logic [19:0] inv_focal_x_q24;
    logic [19:0] inv_focal_y_q24;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    band_low:        9'd0,
    band_high:       9'd256,
    range_near_cm:   10'd100,
    range_far_cm:    10'd140,
    center_x_q8:     18'd86862,
    center_y_q8:     18'd62141,
    inv_focal_x_q24: 20'd28235,
    inv_focal_y_q24: 20'd28386
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] column;
    logic [9:0] row_index;
  } pass_t;

  // record handed from the range stages to the projection stages
  typedef struct packed {
    logic               keep;
    pass_t              pass;
    logic [17:0]        zc;
    logic signed [23:0] point_z;
    logic               neg_x;
    logic               neg_y;
    logic [17:0]        mag_x;
    logic [17:0]        mag_y;
  } depth_t;

  localparam logic [7:0]  CODE_MAX   = 8'd255;
  localparam logic [17:0] DIV_BIAS   = 18'd127;
  localparam logic [8:0]  DIV_RECIP  = 9'd257;
  localparam logic [17:0] DIV_CONST  = 18'd255;
  localparam logic [56:0] ROUND_Q32  = 57'h0_0000_8000_0000;
  localparam logic [23:0] POS_MAX    = 24'h7F_FFFF;
  localparam logic [23:0] NEG_MIN    = 24'h80_0000;

endpackage

// ----- sv/dbpp_if.sv -----
// dbpp_pix_if and dbpp_pt_if: valid/ready channels of the point projector
// pixel request in, point request out
// no dependencies
interface dbpp_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] depth_code;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [9:0] column;
  logic [9:0] row_index;

  modport source (output valid, depth_code, red_in, green_in, blue_in, column, row_index,
                  input ready);
  modport sink (input valid, depth_code, red_in, green_in, blue_in, column, row_index,
                output ready);
endinterface

interface dbpp_pt_if;
  logic               valid;
  logic               ready;
  logic               keep;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic signed [23:0] point_z;
  logic [7:0]         red_out;
  logic [7:0]         green_out;
  logic [7:0]         blue_out;
  logic [9:0]         column_out;
  logic [9:0]         row_out;

  modport source (output valid, keep, point_x, point_y, point_z, red_out, green_out,
                  blue_out, column_out, row_out, input ready);
  modport sink (input valid, keep, point_x, point_y, point_z, red_out, green_out,
                blue_out, column_out, row_out, output ready);
endinterface

// ----- sv/depth_band_point_projector_unit.sv -----
// depth_band_point_projector_unit: top level of the depth band point projector
// depends on dbpp_pkg, dbpp_if, dbpp_regs, dbpp_depth, dbpp_project
//
//   channel   dir   handshake        carries
//   pix_in    in    valid/ready      depth code, color, column, row
//   pt_out    out   valid/ready      keep flag, x/y/z Q15.8, color, column, row
//   apb       in    psel/penable     register writes and reads, pready tied high
//
// one request per cycle sustained while pt_out is ready; a request passes stages 1 to 6 into the output register
// stage count set by the two-step divide by 255 and the split 36x20 projection product
// each of the seven stages advances when empty or when the stage after it moves on
// a full output register waiting on pt_out leaves earlier stages free to fill
// rst is synchronous: pipeline emptied, registers back to their defaults
module depth_band_point_projector_unit #(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbpp_pkg::ADDR_W-1:0] paddr,
  input  logic [dbpp_pkg::DATA_W-1:0] pwdata,
  output logic [dbpp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  dbpp_pix_if.sink                    pix_in,
  dbpp_pt_if.source                   pt_out
);

  dbpp_pkg::cfg_t   cfg;
  dbpp_pkg::depth_t depth;
  logic             depth_valid;
  logic             depth_ready;

  assign pready = 1'b1;

  dbpp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  dbpp_depth #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_depth (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pix_in (pix_in),
    .dvalid (depth_valid),
    .dready (depth_ready),
    .dout   (depth)
  );

  dbpp_project u_project (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .dvalid (depth_valid),
    .dready (depth_ready),
    .din    (depth),
    .pt_out (pt_out)
  );

  // input backpressure only when every stage holds a request and the output stalls
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> (pt_out.valid && !pt_out.ready))
    else $error("input stalled while the pipeline can still advance");

  // dropped pixels carry a zero point
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (pt_out.valid && !pt_out.keep) |->
      (pt_out.point_x == 24'sd0 && pt_out.point_y == 24'sd0 && pt_out.point_z == 24'sd0))
    else $error("dropped pixel with nonzero point");

  // kept pixels lie inside the image
  a_keep_inside: assert property (@(posedge clk) disable iff (rst)
    (pt_out.valid && pt_out.keep) |->
      ({1'b0, pt_out.column_out} < 11'(IMAGE_WIDTH) &&
       {1'b0, pt_out.row_out} < 11'(IMAGE_HEIGHT)))
    else $error("kept pixel outside the image");

endmodule

// ----- sv/dbpp_regs.sv -----
// dbpp_regs: apb configuration registers of the point projector
// depends on dbpp_pkg
module dbpp_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dbpp_pkg::ADDR_W-1:0] paddr,
  input  logic [dbpp_pkg::DATA_W-1:0] pwdata,
  output logic [dbpp_pkg::DATA_W-1:0] prdata,
  output dbpp_pkg::cfg_t             cfg
);

  dbpp_pkg::reg_idx_t idx;

  assign idx = dbpp_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= dbpp_pkg::CFG_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        dbpp_pkg::REG_BAND_LOW:    cfg.band_low        <= pwdata[8:0];
        dbpp_pkg::REG_BAND_HIGH:   cfg.band_high       <= pwdata[8:0];
        dbpp_pkg::REG_RANGE_NEAR:  cfg.range_near_cm   <= pwdata[9:0];
        dbpp_pkg::REG_RANGE_FAR:   cfg.range_far_cm    <= pwdata[9:0];
        dbpp_pkg::REG_CENTER_X:    cfg.center_x_q8     <= pwdata[17:0];
        dbpp_pkg::REG_CENTER_Y:    cfg.center_y_q8     <= pwdata[17:0];
        dbpp_pkg::REG_INV_FOCAL_X: cfg.inv_focal_x_q24 <= pwdata[19:0];
        dbpp_pkg::REG_INV_FOCAL_Y: cfg.inv_focal_y_q24 <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dbpp_pkg::REG_BAND_LOW:    prdata = 32'(cfg.band_low);
      dbpp_pkg::REG_BAND_HIGH:   prdata = 32'(cfg.band_high);
      dbpp_pkg::REG_RANGE_NEAR:  prdata = 32'(cfg.range_near_cm);
      dbpp_pkg::REG_RANGE_FAR:   prdata = 32'(cfg.range_far_cm);
      dbpp_pkg::REG_CENTER_X:    prdata = 32'(cfg.center_x_q8);
      dbpp_pkg::REG_CENTER_Y:    prdata = 32'(cfg.center_y_q8);
      dbpp_pkg::REG_INV_FOCAL_X: prdata = 32'(cfg.inv_focal_x_q24);
      dbpp_pkg::REG_INV_FOCAL_Y: prdata = 32'(cfg.inv_focal_y_q24);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ----- sv/dbpp_depth.sv -----
// dbpp_depth: band test, range from depth code and pixel offsets, four stages
// depends on dbpp_pkg and dbpp_pix_if
module dbpp_depth #(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic                clk,
  input  logic                rst,
  input  dbpp_pkg::cfg_t      cfg,
  dbpp_pix_if.sink            pix_in,
  output logic                dvalid,
  input  logic                dready,
  output dbpp_pkg::depth_t    dout
);

  // stage 1: band test, span, offsets
  logic               v1;
  logic               keep1;
  dbpp_pkg::pass_t    pass1;
  logic [7:0]         diff1;
  logic               span_neg1;
  logic [9:0]         span_mag1;
  logic signed [18:0] dx1;
  logic signed [18:0] dy1;
  // stage 2: span product, offset magnitudes
  logic               v2;
  logic               keep2;
  dbpp_pkg::pass_t    pass2;
  logic               span_neg2;
  logic [17:0]        p2;
  logic               neg_x2;
  logic               neg_y2;
  logic [17:0]        mag_x2;
  logic [17:0]        mag_y2;
  // stage 3: reciprocal estimate of the divide by 255
  logic               v3;
  logic               keep3;
  dbpp_pkg::pass_t    pass3;
  logic               span_neg3;
  logic [17:0]        p3;
  logic [17:0]        num3;
  logic [9:0]         qe3;
  logic               neg_x3;
  logic               neg_y3;
  logic [17:0]        mag_x3;
  logic [17:0]        mag_y3;
  // stage 4 lives in dout
  logic               v4;

  logic rdy1, rdy2, rdy3, rdy4;
  logic keep_next;
  logic [17:0] num_next;
  logic [26:0] recip_prod;
  logic [17:0] rem4;
  logic [9:0]  q4;
  logic [17:0] t4;
  logic signed [19:0] zc4;
  logic [10:0] mid_sum;
  logic signed [20:0] pz4;

  assign rdy4 = !v4 || dready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign pix_in.ready = rdy1;
  assign dvalid = v4;

  assign keep_next = (pix_in.depth_code != 8'd0) &&
                     ({1'b0, pix_in.depth_code} >= cfg.band_low) &&
                     ({1'b0, pix_in.depth_code} < cfg.band_high) &&
                     ({1'b0, pix_in.column} < 11'(IMAGE_WIDTH)) &&
                     ({1'b0, pix_in.row_index} < 11'(IMAGE_HEIGHT));

  assign num_next   = p2 + dbpp_pkg::DIV_BIAS;
  assign recip_prod = 27'(num_next) * 27'(dbpp_pkg::DIV_RECIP);

  assign rem4    = num3 - 18'(18'(qe3) * dbpp_pkg::DIV_CONST);
  assign q4      = qe3 + 10'(rem4 >= dbpp_pkg::DIV_CONST);
  assign t4      = p3 + 18'(q4);
  assign zc4     = span_neg3
                   ? $signed({2'b00, cfg.range_near_cm, 8'd0}) - $signed({2'b00, t4})
                   : $signed({2'b00, cfg.range_near_cm, 8'd0}) + $signed({2'b00, t4});
  assign mid_sum = {1'b0, cfg.range_near_cm} + {1'b0, cfg.range_far_cm};
  assign pz4     = 21'(zc4) - $signed({3'b000, mid_sum[10:1], 8'd0});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= pix_in.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && pix_in.valid) begin
      keep1           <= keep_next;
      pass1.red       <= pix_in.red_in;
      pass1.green     <= pix_in.green_in;
      pass1.blue      <= pix_in.blue_in;
      pass1.column    <= pix_in.column;
      pass1.row_index <= pix_in.row_index;
      diff1           <= dbpp_pkg::CODE_MAX - pix_in.depth_code;
      span_neg1       <= cfg.range_far_cm < cfg.range_near_cm;
      span_mag1       <= (cfg.range_far_cm < cfg.range_near_cm)
                         ? cfg.range_near_cm - cfg.range_far_cm
                         : cfg.range_far_cm - cfg.range_near_cm;
      dx1             <= $signed({1'b0, pix_in.column, 8'd0}) -
                         $signed({1'b0, cfg.center_x_q8});
      dy1             <= $signed({1'b0, pix_in.row_index, 8'd0}) -
                         $signed({1'b0, cfg.center_y_q8});
    end
    if (rdy2 && v1) begin
      keep2     <= keep1;
      pass2     <= pass1;
      span_neg2 <= span_neg1;
      p2        <= 18'(diff1) * 18'(span_mag1);
      neg_x2    <= dx1[18];
      neg_y2    <= dy1[18];
      mag_x2    <= dx1[18] ? 18'(-dx1) : 18'(dx1);
      mag_y2    <= dy1[18] ? 18'(-dy1) : 18'(dy1);
    end
    if (rdy3 && v2) begin
      keep3     <= keep2;
      pass3     <= pass2;
      span_neg3 <= span_neg2;
      p3        <= p2;
      num3      <= num_next;
      qe3       <= recip_prod[25:16];
      neg_x3    <= neg_x2;
      neg_y3    <= neg_y2;
      mag_x3    <= mag_x2;
      mag_y3    <= mag_y2;
    end
    if (rdy4 && v3) begin
      dout.keep    <= keep3;
      dout.pass    <= pass3;
      dout.zc      <= zc4[19] ? 18'd0 : zc4[17:0];
      dout.point_z <= keep3 ? 24'(pz4) : 24'sd0;
      dout.neg_x   <= neg_x3;
      dout.neg_y   <= neg_y3;
      dout.mag_x   <= mag_x3;
      dout.mag_y   <= mag_y3;
    end
  end

endmodule

// ----- sv/dbpp_project.sv -----
// dbpp_project: pinhole back-projection, rounding and saturation, three stages
// depends on dbpp_pkg and dbpp_pt_if
module dbpp_project (
  input  logic             clk,
  input  logic             rst,
  input  dbpp_pkg::cfg_t   cfg,
  input  logic             dvalid,
  output logic             dready,
  input  dbpp_pkg::depth_t din,
  dbpp_pt_if.source        pt_out
);

  // stage 5: offset times range
  logic               v5;
  logic               keep5;
  dbpp_pkg::pass_t    pass5;
  logic signed [23:0] pz5;
  logic               neg_x5;
  logic               neg_y5;
  logic [35:0]        mx5;
  logic [35:0]        my5;
  // stage 6: partial products with the inverse focal lengths
  logic               v6;
  logic               keep6;
  dbpp_pkg::pass_t    pass6;
  logic signed [23:0] pz6;
  logic               neg_x6;
  logic               neg_y6;
  logic [37:0]        xlo6;
  logic [37:0]        xhi6;
  logic [37:0]        ylo6;
  logic [37:0]        yhi6;
  // stage 7: output register
  logic               v7;

  logic rdy5, rdy6, rdy7;
  logic [56:0] prod_x;
  logic [56:0] prod_y;
  logic [23:0] qx;
  logic [23:0] qy;
  logic [23:0] sat_x;
  logic [23:0] sat_y;

  assign rdy7   = !v7 || pt_out.ready;
  assign rdy6   = !v6 || rdy7;
  assign rdy5   = !v5 || rdy6;
  assign dready = rdy5;
  assign pt_out.valid = v7;

  assign prod_x = {1'b0, xhi6, 18'd0} + 57'(xlo6) + dbpp_pkg::ROUND_Q32;
  assign prod_y = {1'b0, yhi6, 18'd0} + 57'(ylo6) + dbpp_pkg::ROUND_Q32;
  assign qx     = prod_x[55:32];
  assign qy     = prod_y[55:32];

  always_comb begin
    if (neg_x6) begin
      sat_x = (qx >= dbpp_pkg::NEG_MIN) ? dbpp_pkg::NEG_MIN : 24'(-qx);
    end else begin
      sat_x = (qx > dbpp_pkg::POS_MAX) ? dbpp_pkg::POS_MAX : qx;
    end
    if (neg_y6) begin
      sat_y = (qy >= dbpp_pkg::NEG_MIN) ? dbpp_pkg::NEG_MIN : 24'(-qy);
    end else begin
      sat_y = (qy > dbpp_pkg::POS_MAX) ? dbpp_pkg::POS_MAX : qy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy5) v5 <= dvalid;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && dvalid) begin
      keep5  <= din.keep;
      pass5  <= din.pass;
      pz5    <= din.point_z;
      neg_x5 <= din.neg_x;
      neg_y5 <= din.neg_y;
      mx5    <= 36'(din.mag_x) * 36'(din.zc);
      my5    <= 36'(din.mag_y) * 36'(din.zc);
    end
    if (rdy6 && v5) begin
      keep6  <= keep5;
      pass6  <= pass5;
      pz6    <= pz5;
      neg_x6 <= neg_x5;
      neg_y6 <= neg_y5;
      xlo6   <= 38'(mx5[17:0]) * 38'(cfg.inv_focal_x_q24);
      xhi6   <= 38'(mx5[35:18]) * 38'(cfg.inv_focal_x_q24);
      ylo6   <= 38'(my5[17:0]) * 38'(cfg.inv_focal_y_q24);
      yhi6   <= 38'(my5[35:18]) * 38'(cfg.inv_focal_y_q24);
    end
    if (rdy7 && v6) begin
      pt_out.keep       <= keep6;
      pt_out.point_x    <= keep6 ? $signed(sat_x) : 24'sd0;
      pt_out.point_y    <= keep6 ? $signed(sat_y) : 24'sd0;
      pt_out.point_z    <= pz6;
      pt_out.red_out    <= pass6.red;
      pt_out.green_out  <= pass6.green;
      pt_out.blue_out   <= pass6.blue;
      pt_out.column_out <= pass6.column;
      pt_out.row_out    <= pass6.row_index;
    end
  end

endmodule
